/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the stats monitor.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* sv/escm_pkg.sv */
// ---------------------------------------------------------------------------
// escm_pkg
// Types and constants of the error stats convergence monitor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package escm_pkg;

  localparam int ERR_W      = 32;
  localparam int POS_SUM_W  = 55;
  localparam int SUM_W      = 56;
  localparam int MEAN_W     = 32;
  localparam int OUT_CNT_W  = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int FAIL_W     = 8;
  localparam int TARGET_W   = 31;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] NEG_MAG_MAX = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b1, {(MEAN_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEAK_THRESH   = 2'd0,
    REG_REDUCE_THRESH = 2'd1,
    REG_TARGET        = 2'd2,
    REG_FAILED_MAX    = 2'd3
  } cfg_reg_t;

  // Item kinds on the input channel
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_END    = 1'b1
  } item_kind_t;

  // Iteration outcome codes
  typedef enum logic [2:0] {
    OC_FIRST     = 3'd0,
    OC_NO_SAMPLE = 3'd1,
    OC_INCREASED = 3'd2,
    OC_LOW_RED   = 3'd3,
    OC_REDUCED   = 3'd4
  } outcome_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  // Accumulated statistics (counts travel separately, their width is a parameter)
  typedef struct packed {
    logic signed [ERR_W-1:0] min_v;
    logic signed [ERR_W-1:0] max_v;
    logic [POS_SUM_W-1:0]    pos_sum;
    logic [SUM_W-1:0]        neg_mag;
    logic [SUM_W-1:0]        abs_sum;
  } acc_stats_t;

endpackage

/* sv/escm_in_if.sv */
// ---------------------------------------------------------------------------
// escm_in_if
// Input request channel: error samples and end-of-iteration marks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface escm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] error_value;
  logic [31:0] weight;

  modport source (output valid, kind, error_value, weight, input ready);
  modport sink   (input valid, kind, error_value, weight, output ready);
endinterface

/* sv/escm_out_if.sv */
// ---------------------------------------------------------------------------
// escm_out_if
// Result request channel: one stats record per iteration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface escm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] min_error;
  logic [31:0] max_error;
  logic [54:0] positive_sum;
  logic [23:0] positive_count;
  logic [55:0] negative_sum;
  logic [23:0] negative_count;
  logic [55:0] absolute_sum;
  logic [23:0] sample_count;
  logic [31:0] mean_abs_error;
  logic [2:0]  outcome;
  logic [7:0]  failed_count;
  logic        converged;

  modport source (output valid, min_error, max_error, positive_sum, positive_count,
                  negative_sum, negative_count, absolute_sum, sample_count,
                  mean_abs_error, outcome, failed_count, converged,
                  input ready);
  modport sink   (input valid, min_error, max_error, positive_sum, positive_count,
                  negative_sum, negative_count, absolute_sum, sample_count,
                  mean_abs_error, outcome, failed_count, converged,
                  output ready);
endinterface

/* sv/escm_acc.sv */
// ---------------------------------------------------------------------------
// escm_acc
// Per-iteration accumulators: min, max, saturating sums and counts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module escm_acc
  import escm_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_en,
  input  logic                    clear,
  input  logic [ERR_W-1:0]        error_value,
  input  logic [31:0]             weight,
  input  logic [31:0]             weak_thresh,
  output acc_stats_t              stats,
  output logic [COUNT_BITS-1:0]   pos_count,
  output logic [COUNT_BITS-1:0]   neg_count,
  output logic [COUNT_BITS-1:0]   abs_count
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic signed [ERR_W-1:0] e;
  logic                    take;
  logic [ERR_W-1:0]        mag;
  logic [POS_SUM_W:0]      pos_sum_ext;
  logic [SUM_W:0]          neg_sum_ext;
  logic [SUM_W:0]          abs_sum_ext;

  assign e = error_value;

  // Drop weak samples and the sentinel code
  assign take = sample_en && (weight >= weak_thresh) && (e != ERR_MAX);

  // Magnitude fits 32 bits unsigned, including the most negative code
  assign mag = e[ERR_W-1] ? (ERR_W'(0) - error_value) : error_value;

  assign pos_sum_ext = {1'b0, stats.pos_sum} + (POS_SUM_W+1)'(mag);
  assign neg_sum_ext = {1'b0, stats.neg_mag} + (SUM_W+1)'(mag);
  assign abs_sum_ext = {1'b0, stats.abs_sum} + (SUM_W+1)'(mag);

  // Update or clear the accumulators
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      stats.min_v   <= ERR_MAX;
      stats.max_v   <= ERR_MIN;
      stats.pos_sum <= '0;
      stats.neg_mag <= '0;
      stats.abs_sum <= '0;
      pos_count     <= '0;
      neg_count     <= '0;
      abs_count     <= '0;
    end else if (take) begin
      if (e > stats.max_v) stats.max_v <= e;
      if (e < stats.min_v) stats.min_v <= e;
      if (e > 0) begin
        stats.pos_sum <= pos_sum_ext[POS_SUM_W] ? '1 : pos_sum_ext[POS_SUM_W-1:0];
        if (pos_count != CNT_MAX) pos_count <= pos_count + 1'b1;
      end else if (e < 0) begin
        stats.neg_mag <= (neg_sum_ext > (SUM_W+1)'(NEG_MAG_MAX)) ? NEG_MAG_MAX
                                                                 : neg_sum_ext[SUM_W-1:0];
        if (neg_count != CNT_MAX) neg_count <= neg_count + 1'b1;
      end
      stats.abs_sum <= abs_sum_ext[SUM_W] ? '1 : abs_sum_ext[SUM_W-1:0];
      if (abs_count != CNT_MAX) abs_count <= abs_count + 1'b1;
    end
  end

endmodule

/* sv/escm_div.sv */
// ---------------------------------------------------------------------------
// escm_div
// Restoring divider, one quotient bit per cycle: absolute sum by count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module escm_div
  import escm_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   diff;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[COUNT_BITS]) begin
        rem <= diff[COUNT_BITS-1:0];
      end else begin
        rem <= rem_sh[COUNT_BITS-1:0];
      end
      quotient <= {quotient[SUM_W-2:0], ~diff[COUNT_BITS]};
    end
  end

endmodule

/* sv/error_stats_convergence_monitor_core.sv */
// ---------------------------------------------------------------------------
// error_stats_convergence_monitor_core
// Error statistics over an iteration, mean absolute error and convergence.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                    | handshake
//  in_ch    | in  | kind, error_value, weight                  | valid/ready
//  out_ch   | out | min/max, sums, counts, mean, outcome, ...  | valid/ready
//  cfg      | in  | cfg_index, cfg_data                        | cfg_we only
//
//  A sample request is taken whenever it is valid in idle; ready stays high in idle.
//  An end-of-iteration request holds ready low through the divide state (one
//  quotient bit per divider step), the divider's done pulse, the multiply state
//  and the finish state; with no samples only the multiply and finish states.
//  Reset is synchronous on rst; it clears the control, accumulator, history,
//  configuration and output valid state, but not the mean, the products or
//  the output payload; there is no clearing pass. The result sits in an output
//  register; the finish cycle waits while that register still holds a result that has not been taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module error_stats_convergence_monitor_core
  import escm_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  escm_in_if.sink               in_ch,
  escm_out_if.source            out_ch
);

  // Configuration registers
  logic [31:0]         weak_thresh;
  logic [31:0]         reduce_thresh;
  logic [TARGET_W-1:0] target_err;
  logic [FAIL_W-1:0]   failed_max;

  // Sequencer and history
  state_t            state;
  state_t            state_next;
  logic [MEAN_W-1:0] mean;
  logic              mean_valid;
  logic [63:0]       prod;
  logic [47:0]       red_sh;
  logic [MEAN_W-1:0] prev_mean;
  logic              prev_valid;
  logic              has_history;
  logic [FAIL_W-1:0] fail_counter;

  // Accumulator and divider links
  acc_stats_t            stats;
  logic [COUNT_BITS-1:0] pos_count;
  logic [COUNT_BITS-1:0] neg_count;
  logic [COUNT_BITS-1:0] abs_count;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;
  logic [MEAN_W-1:0]     quot_clamped;

  logic in_accept;
  logic sample_en;
  logic end_accept;
  logic load_out;
  logic out_free;

  logic              low_red;
  outcome_t          outcome;
  logic [FAIL_W-1:0] fail_next;
  logic              conv;
  logic [31:0]       pc_ext;
  logic [31:0]       nc_ext;
  logic [31:0]       ac_ext;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      weak_thresh   <= 32'd0;
      reduce_thresh <= 32'd3277;
      target_err    <= TARGET_W'(1);
      failed_max    <= FAIL_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEAK_THRESH:   weak_thresh   <= cfg_data;
        REG_REDUCE_THRESH: reduce_thresh <= cfg_data;
        REG_TARGET:        target_err    <= cfg_data[TARGET_W-1:0];
        REG_FAILED_MAX:    failed_max    <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign sample_en  = in_accept && (item_kind_t'(in_ch.kind) == KIND_SAMPLE);
  assign end_accept = in_accept && (item_kind_t'(in_ch.kind) == KIND_END);
  assign out_free   = !out_ch.valid || out_ch.ready;

  escm_acc #(.COUNT_BITS(COUNT_BITS)) u_acc (
    .clk         (clk),
    .rst         (rst),
    .sample_en   (sample_en),
    .clear       (load_out),
    .error_value (in_ch.error_value),
    .weight      (in_ch.weight),
    .weak_thresh (weak_thresh),
    .stats       (stats),
    .pos_count   (pos_count),
    .neg_count   (neg_count),
    .abs_count   (abs_count)
  );

  escm_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (stats.abs_sum),
    .divisor  (abs_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp the quotient to 2^31
  assign quot_clamped = ((quotient[SUM_W-1:MEAN_W] != '0) ||
                         (quotient[MEAN_W-1] && (quotient[MEAN_W-2:0] != '0)))
                        ? MEAN_MAX : quotient[MEAN_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (end_accept) state_next = (abs_count != '0) ? S_DIV : S_MUL;
      S_DIV:  if (div_done) state_next = S_MUL;
      S_MUL:  state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        div_start   = end_accept && (abs_count != '0);
      end
      S_FIN:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the mean and form the reduction products
  always_ff @(posedge clk) begin
    if (state == S_IDLE && end_accept) begin
      mean       <= '0;
      mean_valid <= (abs_count != '0);
    end else if (state == S_DIV && div_done) begin
      mean <= quot_clamped;
    end
    if (state == S_MUL) begin
      prod   <= 64'(reduce_thresh) * 64'(mean);
      red_sh <= {prev_mean - mean, 16'd0};
    end
  end

  // Classify the iteration
  always_comb begin
    low_red = 1'b0;
    if (mean_valid && prev_valid && (mean <= prev_mean)) begin
      if (mean != '0) begin
        low_red = {16'd0, red_sh} < prod;
      end else begin
        low_red = (reduce_thresh != '0);
      end
    end
    priority if (!has_history)              outcome = OC_FIRST;
    else if (!mean_valid || !prev_valid)    outcome = OC_NO_SAMPLE;
    else if (mean > prev_mean)              outcome = OC_INCREASED;
    else if (low_red)                       outcome = OC_LOW_RED;
    else                                    outcome = OC_REDUCED;
    if (!has_history || outcome == OC_REDUCED) begin
      fail_next = '0;
    end else begin
      fail_next = (fail_counter == '1) ? fail_counter : fail_counter + 1'b1;
    end
    conv = (mean_valid && (mean < {1'b0, target_err})) || (fail_next >= failed_max);
  end

  // History registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mean    <= '0;
      prev_valid   <= 1'b0;
      has_history  <= 1'b0;
      fail_counter <= '0;
    end else if (load_out) begin
      prev_mean    <= mean;
      prev_valid   <= mean_valid;
      has_history  <= 1'b1;
      fail_counter <= fail_next;
    end
  end

  assign pc_ext = 32'(pos_count);
  assign nc_ext = 32'(neg_count);
  assign ac_ext = 32'(abs_count);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.min_error      <= stats.min_v;
      out_ch.max_error      <= stats.max_v;
      out_ch.positive_sum   <= stats.pos_sum;
      out_ch.positive_count <= pc_ext[OUT_CNT_W-1:0];
      out_ch.negative_sum   <= SUM_W'(0) - stats.neg_mag;
      out_ch.negative_count <= nc_ext[OUT_CNT_W-1:0];
      out_ch.absolute_sum   <= stats.abs_sum;
      out_ch.sample_count   <= ac_ext[OUT_CNT_W-1:0];
      out_ch.mean_abs_error <= mean;
      out_ch.outcome        <= outcome;
      out_ch.failed_count   <= fail_next;
      out_ch.converged      <= conv;
    end
  end

  // Checks
  `ASSERT_SAME(a_div_done_in_div, clk, rst, div_done, state == S_DIV,
               "divider done outside divide state")
  `ASSERT_SAME(a_no_overwrite, clk, rst, load_out, !out_ch.valid || out_ch.ready,
               "result overwritten before taken")
  `ASSERT_NEXT(a_clear_after_load, clk, rst, load_out,
               (abs_count == '0) && (stats.abs_sum == '0), "accumulators not cleared")

endmodule
